// File: rtl/fhp_pkg.sv
package fhp_pkg;

    // Filter length and derived widths.
    localparam int TAPS   = 64;
    localparam int TAP_W  = $clog2(TAPS);
    localparam int DATA_W = 16;
    localparam int IDX_W  = 6;
    localparam int PROD_W = 2 * DATA_W;
    // One guard bit per doubling of the tap count keeps the exact sum.
    localparam int ACC_W  = PROD_W + TAP_W;

    // Rounding offset and saturation limits of the Q8.30 sum.
    localparam int    FRAC_W   = DATA_W - 1;
    localparam int    ROUND    = 1 << (FRAC_W - 1);
    localparam longint SAT_HI  = 64'sd1 << (2 * FRAC_W);
    localparam longint SAT_LO  = -(64'sd1 << (2 * FRAC_W));

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic coef_we;
        logic delay_we;
        logic acc_clear;
        logic issue;
        logic out_load;
        logic wp_advance;
    } fhp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tap_last;
        logic acc_done;
        logic out_full;
    } fhp_sts_t;

endpackage

// File: rtl/fir_highpass_filter.sv
// Direct-form FIR high-pass filter with 64 taps on a Q1.15 audio stream. Each
// input item is either a coefficient load (kind = 1), which writes one Q1.15 tap
// weight and produces no result, or an audio sample (kind = 0), which is shifted
// into the delay line and produces one filtered sample: the sum of all taps of
// delayed sample times weight, with the newest sample on tap 0, rounded half up
// to Q1.15 and saturated, with m_clipped set when saturation occurred. Delay line
// and weights read as zero after reset. A coefficient load completes in the
// cycle it is accepted. Samples use the single shared multiply-accumulate,
// which visits one tap per cycle through the read, multiply and accumulate
// stages. A finished result waits in an output register, so new items are
// taken while it is still pending; if a second sum is ready before the first
// is taken, the block waits in its final step until the output frees up.
module fir_highpass_filter
    import fhp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic signed [DATA_W-1:0] s_sample_in,
    input  logic        [IDX_W-1:0]  s_coef_index,
    input  logic signed [DATA_W-1:0] s_coef_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_filtered,
    output logic                     m_clipped
);

    // Commands flow from the controller to the datapath; status flows back.
    fhp_cmd_t cmd;
    fhp_sts_t sts;

    // The controller sequences each item: coefficient writes complete at once,
    // samples run through the tap loop and then load the output register.
    fhp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds both memories, the multiply-accumulate pipeline,
    // the rounding and saturation logic, and the output register.
    fhp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .sample_in  (s_sample_in),
        .coef_index (s_coef_index),
        .coef_value (s_coef_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered),
        .m_clipped  (m_clipped)
    );

endmodule

// File: rtl/fhp_ctrl.sv
module fhp_ctrl
    import fhp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_kind,
    output logic     s_ready,
    input  fhp_sts_t sts,
    output fhp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_COEF) begin
                        cmd.coef_we = 1'b1;
                    end else begin
                        cmd.delay_we  = 1'b1;
                        cmd.acc_clear = 1'b1;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (sts.tap_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (sts.acc_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold the sum until the output register is free.
                if (!sts.out_full) begin
                    cmd.out_load   = 1'b1;
                    cmd.wp_advance = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_full)
        else $error("result loaded into a full output register");

    a_wait_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WAIT |=> state_reg == ST_WAIT || state_reg == ST_FINISH)
        else $error("left the drain state other than to finish");

    a_no_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> !sts.acc_done)
        else $error("accumulation finished while taps were still issued");

endmodule

// File: rtl/fhp_datapath.sv
module fhp_datapath
    import fhp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fhp_cmd_t                 cmd,
    output fhp_sts_t                 sts,
    input  logic signed [DATA_W-1:0] sample_in,
    input  logic        [IDX_W-1:0]  coef_index,
    input  logic signed [DATA_W-1:0] coef_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_filtered,
    output logic                     m_clipped
);

    // Coefficient and delay memories; valid bits stand in for the zero reset.
    logic signed [DATA_W-1:0] coef_mem  [TAPS];
    logic signed [DATA_W-1:0] delay_mem [TAPS];
    logic [TAPS-1:0]          coef_vld_reg;
    logic [TAPS-1:0]          delay_vld_reg;

    logic [TAP_W-1:0] wp_reg;
    logic [TAP_W-1:0] tap_reg;
    logic [TAP_W-1:0] delay_raddr;
    logic [TAP_W-1:0] coef_waddr;
    logic             coef_in_range;

    logic signed [DATA_W-1:0] coef_rd_reg;
    logic signed [DATA_W-1:0] delay_rd_reg;
    logic                     coef_rv_reg;
    logic                     delay_rv_reg;
    logic                     rd_vld_reg;
    logic                     rd_last_reg;

    logic signed [DATA_W-1:0] coef_op;
    logic signed [DATA_W-1:0] delay_op;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_done_reg;

    logic signed [ACC_W:0]    rounded;
    logic signed [DATA_W-1:0] sat_val;
    logic                     sat_flag;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] filtered_reg;
    logic                     clipped_reg;

    assign coef_in_range = (int'(coef_index) < TAPS);
    assign coef_waddr    = TAP_W'(coef_index);

    // Delay slot of the current tap: newest sample at tap 0, walking backward.
    always_comb begin
        if (tap_reg > wp_reg) begin
            delay_raddr = TAP_W'(({1'b0, wp_reg} + (TAP_W+1)'(TAPS)) - {1'b0, tap_reg});
        end else begin
            delay_raddr = wp_reg - tap_reg;
        end
    end

    assign sts.tap_last = cmd.issue && (tap_reg == TAP_W'(TAPS - 1));
    assign sts.acc_done = acc_done_reg;
    assign sts.out_full = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.coef_we && coef_in_range) begin
            coef_mem[coef_waddr] <= coef_value;
        end
        coef_rd_reg <= coef_mem[tap_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.delay_we) begin
            delay_mem[wp_reg] <= sample_in;
        end
        delay_rd_reg <= delay_mem[delay_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg  <= '0;
            delay_vld_reg <= '0;
            coef_rv_reg   <= 1'b0;
            delay_rv_reg  <= 1'b0;
        end else begin
            if (cmd.coef_we && coef_in_range) begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (cmd.delay_we) begin
                delay_vld_reg[wp_reg] <= 1'b1;
            end
            coef_rv_reg  <= coef_vld_reg[tap_reg];
            delay_rv_reg <= delay_vld_reg[delay_raddr];
        end
    end

    // Tap counter and write pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
            wp_reg  <= '0;
        end else begin
            if (cmd.acc_clear) begin
                tap_reg <= '0;
            end else if (cmd.issue && !sts.tap_last) begin
                tap_reg <= tap_reg + TAP_W'(1);
            end
            if (cmd.wp_advance) begin
                if (wp_reg == TAP_W'(TAPS - 1)) begin
                    wp_reg <= '0;
                end else begin
                    wp_reg <= wp_reg + TAP_W'(1);
                end
            end
        end
    end

    // Read, multiply and accumulate stages.
    assign coef_op  = coef_rv_reg  ? coef_rd_reg  : '0;
    assign delay_op = delay_rv_reg ? delay_rd_reg : '0;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(coef_op * delay_op);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_done_reg  <= 1'b0;
            acc_reg       <= '0;
        end else begin
            rd_vld_reg    <= cmd.issue;
            rd_last_reg   <= sts.tap_last;
            prod_vld_reg  <= rd_vld_reg;
            prod_last_reg <= rd_last_reg;
            if (cmd.acc_clear) begin
                acc_reg      <= '0;
                acc_done_reg <= 1'b0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
                if (prod_last_reg) begin
                    acc_done_reg <= 1'b1;
                end
            end
        end
    end

    // Round half up to Q1.15, then saturate.
    always_comb begin
        rounded = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(ROUND);
        if (rounded >= SAT_HI) begin
            sat_val  = {1'b0, {(DATA_W-1){1'b1}}};
            sat_flag = 1'b1;
        end else if (rounded < SAT_LO) begin
            sat_val  = {1'b1, {(DATA_W-1){1'b0}}};
            sat_flag = 1'b1;
        end else begin
            sat_val  = rounded[2*FRAC_W:FRAC_W];
            sat_flag = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            filtered_reg <= sat_val;
            clipped_reg  <= sat_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = filtered_reg;
    assign m_clipped  = clipped_reg;

    a_load_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> acc_done_reg)
        else $error("result loaded before the last product was accumulated");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("output became valid without a result load");

    a_wp_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.wp_advance |=> $stable(wp_reg))
        else $error("write pointer moved without a finished sample");

endmodule

// File: test/testbench.sv
module testbench;
    import fhp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog gives up after this many cycles in which no item moves on
    // either channel, which leaves a wide margin over a sample pass with random
    // stalls on both sides.
    localparam int STALL_LIMIT = 4000;
    // Cycles to linger after the last expected item has arrived. This covers a
    // full sample pass, so a stray extra result would still be seen.
    localparam int DRAIN_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int DIRECTED_ROWS = 21;

    // One result item of the filter.
    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     clipped;
    } filter_out_t;

    // One row of the directed table. When typed_in is set, the expected result
    // is written in the row itself and the predictor only tracks state.
    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] sample;
        logic        [IDX_W-1:0]  index;
        logic signed [DATA_W-1:0] weight;
        logic                     typed_in;
        logic signed [DATA_W-1:0] want_filtered;
        logic                     want_clipped;
    } step_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_kind;
    logic signed [DATA_W-1:0] s_sample_in;
    logic        [IDX_W-1:0]  s_coef_index;
    logic signed [DATA_W-1:0] s_coef_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_filtered;
    logic                     m_clipped;

    // Predictor state: the delay line, its write position and the tap weights,
    // kept at the same widths as the block.
    logic signed [DATA_W-1:0] history [TAPS];
    logic        [TAP_W-1:0]  history_head;
    logic signed [DATA_W-1:0] weight_mirror [TAPS];

    // Results that the block owes us, oldest first.
    filter_out_t pending_outputs [$];
    filter_out_t oldest_output;

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int stall_cycles;

    // The directed part. It starts with samples on an all-zero filter, then
    // loads the extreme weight on tap 0 and tap 1 to drive the sum past both
    // saturation limits, touches the highest tap index, and then uses a
    // half-weight tap that shows the half-up rounding on both signs. Unused
    // fields carry junk so that the block must ignore them.
    step_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // Zero weights after reset: every sample filters to zero.
        '{KIND_SAMPLE,  16'sd12345,  6'd63,  -16'sd1,     1'b1, 16'sd0,      1'b0},
        '{KIND_SAMPLE, -16'sd32768,  6'd0,   16'sd32767,  1'b1, 16'sd0,      1'b0},
        '{KIND_SAMPLE,  16'sd32767,  6'd21,  16'sd0,      1'b1, 16'sd0,      1'b0},
        // Tap 0 set to -1.0; the sample field is junk here.
        '{KIND_COEF,    16'sh5a5a,   6'd0,  -16'sd32768,  1'b0, 16'sd0,      1'b0},
        // -1.0 times -1.0 is +1.0, which does not fit: positive overflow.
        '{KIND_SAMPLE, -16'sd32768,  6'd7,   16'sd100,    1'b1, 16'sd32767,  1'b1},
        // Largest sample times -1.0 lands just inside the range.
        '{KIND_SAMPLE,  16'sd32767,  6'd9,  -16'sd100,    1'b1, -16'sd32767, 1'b0},
        '{KIND_COEF,   -16'sd1,      6'd1,  -16'sd32768,  1'b0, 16'sd0,      1'b0},
        // Two taps of -1.0 against two largest samples: negative overflow.
        '{KIND_SAMPLE,  16'sd32767,  6'd2,   16'sd3,      1'b1, -16'sd32768, 1'b1},
        '{KIND_SAMPLE, -16'sd32768,  6'd3,   16'sd4,      1'b0, 16'sd0,      1'b0},
        '{KIND_SAMPLE, -16'sd32768,  6'd4,   16'sd5,      1'b1, 16'sd32767,  1'b1},
        // Highest tap index.
        '{KIND_COEF,    16'sd0,      6'd63,  16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{KIND_SAMPLE,  16'sd0,      6'd5,   16'sd6,      1'b0, 16'sd0,      1'b0},
        // Leave only tap 0 at one half.
        '{KIND_COEF,    16'sd1,      6'd0,   16'sd16384,  1'b0, 16'sd0,      1'b0},
        '{KIND_COEF,    16'sd2,      6'd1,   16'sd0,      1'b0, 16'sd0,      1'b0},
        '{KIND_COEF,    16'sd3,      6'd63,  16'sd0,      1'b0, 16'sd0,      1'b0},
        // One LSB times one half is exactly half an LSB: rounds up to one.
        '{KIND_SAMPLE,  16'sd1,      6'd6,   16'sd7,      1'b1, 16'sd1,      1'b0},
        // Minus half an LSB rounds up to zero.
        '{KIND_SAMPLE, -16'sd1,      6'd8,   16'sd8,      1'b1, 16'sd0,      1'b0},
        '{KIND_SAMPLE,  16'sh7fff,   6'd10,  16'sd9,      1'b0, 16'sd0,      1'b0},
        '{KIND_COEF,   -16'sd1,      6'd42,  16'sh1234,   1'b0, 16'sd0,      1'b0},
        '{KIND_SAMPLE, -16'sd12345,  6'd63, -16'sd32768,  1'b0, 16'sd0,      1'b0},
        '{KIND_SAMPLE,  16'sh5555,   6'd11,  16'sh7fff,   1'b0, 16'sd0,      1'b0}
    };

    fir_highpass_filter DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_sample_in  (s_sample_in),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_clipped    (m_clipped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one accepted item to the predictor state. A load updates one
    // weight and yields nothing. A sample enters the delay line at the write
    // position, so the newest sample meets tap 0 and the one i samples old meets
    // tap i. The exact sum is rounded half up to Q1.15 and then saturated.
    task automatic filter_step(input logic kind,
                               input logic signed [DATA_W-1:0] sample,
                               input logic [IDX_W-1:0] index,
                               input logic signed [DATA_W-1:0] weight,
                               output bit produced,
                               output filter_out_t result);
        longint            acc;
        longint            rounded;
        logic [TAP_W-1:0]  pos;
        produced = 1'b0;
        result   = '0;
        if (kind == KIND_COEF) begin
            if (int'(index) < TAPS) begin
                weight_mirror[index] = weight;
            end
        end else begin
            history[history_head] = sample;
            acc = 0;
            for (int i = 0; i < TAPS; i++) begin
                pos = history_head - TAP_W'(i);
                acc += longint'(history[pos]) * longint'(weight_mirror[i]);
            end
            history_head = history_head + 1'b1;
            rounded = acc + ROUND;
            if (rounded >= SAT_HI) begin
                result.filtered = 16'sd32767;
                result.clipped  = 1'b1;
            end else if (rounded < SAT_LO) begin
                result.filtered = -16'sd32768;
                result.clipped  = 1'b1;
            end else begin
                result.filtered = DATA_W'(rounded >>> FRAC_W);
                result.clipped  = 1'b0;
            end
            produced = 1'b1;
        end
    endtask

    // Random Q1.15 value: the two extremes, small values near zero, or the
    // full range.
    function automatic logic signed [DATA_W-1:0] random_q15(input int small_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return -16'sd32768;
        end else if (pick < 16) begin
            return 16'sd32767;
        end else if (pick < 16 + small_pct) begin
            return DATA_W'($urandom_range(2047)) - 16'sd1024;
        end
        return DATA_W'($urandom);
    endfunction

    // Offers one item on the input channel and, once the block has taken it,
    // records what the block owes for it. The sender first idles at random.
    // Valid is only ever set once per edge, so back-to-back items keep it high.
    task automatic push_item(input logic kind,
                             input logic signed [DATA_W-1:0] sample,
                             input logic [IDX_W-1:0] index,
                             input logic signed [DATA_W-1:0] weight,
                             input logic typed_in,
                             input filter_out_t typed_result);
        bit          produced;
        filter_out_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_sample_in  <= sample;
        s_coef_index <= index;
        s_coef_value <= weight;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        filter_step(kind, sample, index, weight, produced, predicted);
        if (produced) begin
            pending_outputs.push_back(typed_in ? typed_result : predicted);
        end
    endtask

    // The receiver drops ready at random, at the rate of the current phase.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result item is checked against the oldest outstanding expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: result item with nothing expected: filtered=%0d clipped=%0b",
                         $time, m_filtered, m_clipped);
                fail_count++;
            end else begin
                oldest_output = pending_outputs.pop_front();
                if (m_filtered !== oldest_output.filtered) begin
                    $display("%0t: filtered mismatch: expected %0d, actual %0d",
                             $time, oldest_output.filtered, m_filtered);
                    fail_count++;
                end
                if (m_clipped !== oldest_output.clipped) begin
                    $display("%0t: clipped mismatch: expected %0b, actual %0b",
                             $time, oldest_output.clipped, m_clipped);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which nothing moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        filter_out_t typed_result;
        logic        load;

        fail_count    = 0;
        stall_cycles  = 0;
        send_idle_pct = 24;
        recv_idle_pct = 45;
        history_head  = '0;
        for (int i = 0; i < TAPS; i++) begin
            history[i]       = '0;
            weight_mirror[i] = '0;
        end

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_kind       <= KIND_SAMPLE;
        s_sample_in  <= '0;
        s_coef_index <= '0;
        s_coef_value <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, run under the idling of the first phase.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            typed_result.filtered = directed_rows[r].want_filtered;
            typed_result.clipped  = directed_rows[r].want_clipped;
            push_item(directed_rows[r].kind, directed_rows[r].sample,
                      directed_rows[r].index, directed_rows[r].weight,
                      directed_rows[r].typed_in, typed_result);
        end

        // Random items in three phases: sender idles less than the receiver,
        // then the reverse, then neither idles. About a quarter of the items
        // reload a weight; small weights dominate so that many sums stay in
        // range while the extremes still drive saturation now and then.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                load = ($urandom_range(3) == 0) ? KIND_COEF : KIND_SAMPLE;
                push_item(load, random_q15(30), IDX_W'($urandom), random_q15(60),
                          1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        // Wait for every owed result, then linger to catch any extra one.
        while (pending_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_outputs.size() != 0) begin
            $display("%0t: %0d expected result items never arrived",
                     $time, pending_outputs.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
